/* rtl/replay_gain_sample_scaler_defines.svh */
// assertion macros for the replay gain sample scaler checker
`ifndef REPLAY_GAIN_SAMPLE_SCALER_DEFINES_SVH
`define REPLAY_GAIN_SAMPLE_SCALER_DEFINES_SVH

// checked only while out of reset
`define RGSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define RGSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/rgss_pkg.sv */
// shared types, constants and tables of the replay gain sample scaler
package rgss_pkg;

    localparam logic [31:0] UNITY_GAIN = 32'h0080_0000;
    localparam logic signed [15:0] GAIN_LIMIT = 16'sd12800;
    localparam logic [13:0] DB_STEP = 14'd5120;
    localparam int POW_DEPTH = 13;

    // 10^(2^b/5120) in Q3.29
    localparam logic [31:0] POW_TABLE [POW_DEPTH] = '{
        32'd537112410, 32'd537354016, 32'd537837555, 32'd538805939, 32'd540747941,
        32'd544652968, 32'd552547826, 32'd568682513, 32'd602379071, 32'd675880434,
        32'd850883054, 32'd1348558759, 32'd3387426450
    };

    // register indexes
    localparam logic [2:0] REG_TRACK   = 3'd0;
    localparam logic [2:0] REG_ALBUM   = 3'd1;
    localparam logic [2:0] REG_PREFER  = 3'd2;
    localparam logic [2:0] REG_PRESENT = 3'd3;
    localparam logic [2:0] REG_FORMAT  = 3'd4;

    typedef enum logic [1:0] {
        FMT_S16 = 2'd0,
        FMT_S32 = 2'd1,
        FMT_F32 = 2'd2,
        FMT_RAW = 2'd3
    } fmt_t;

    typedef struct packed {
        logic signed [15:0] track_gain_db;
        logic signed [15:0] album_gain_db;
        logic               prefer_album;
        logic               metadata_present;
    } gain_cfg_t;

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_START,
        GS_MUL,
        GS_SCALE,
        GS_POS,
        GS_DIVINIT,
        GS_DIV
    } gain_state_t;

    // one pipeline stage worth of payload
    typedef struct packed {
        fmt_t               fmt;
        logic [31:0]        raw;
        logic               last;
        logic               neg;
        logic               spec;
        logic [31:0]        mag;
        logic [7:0]         e;
        logic [63:0]        p;
        logic [5:0]         h;
        logic [31:0]        res;
        logic signed [10:0] ex;
        logic [24:0]        mant;
        logic               rb;
        logic               st;
    } stage_t;

endpackage

/* rtl/rgss_gain.sv */
// gain sequencer: picks the dB value and turns it into a linear Q9.23 factor
module rgss_gain (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  rgss_pkg::gain_cfg_t   cfg,
    output logic                  busy,
    output logic [31:0]           linear_gain
);

    rgss_pkg::gain_state_t state_reg, state_next;
    logic [31:0] gain_reg, gain_next;
    logic [31:0] acc_reg, acc_next;
    logic [38:0] a_reg, a_next;
    logic [51:0] num_reg, num_next;
    logic [38:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [3:0]  bit_reg, bit_next;
    logic [12:0] r_reg, r_next;
    logic [1:0]  k_reg, k_next;
    logic        neg_reg, neg_next;

    logic               ok_t, ok_a, use_g;
    logic signed [15:0] raw;
    logic [15:0]        m16;
    logic [13:0]        m14;
    logic [1:0]         k_sel;
    logic [13:0]        r_wide;
    logic [63:0]        prod;
    logic [64:0]        prod_rnd;
    logic [6:0]         mult;
    logic [39:0]        rem_sh;
    logic               qb;

    always_comb begin
        ok_t = (cfg.track_gain_db > -rgss_pkg::GAIN_LIMIT) &&
               (cfg.track_gain_db < rgss_pkg::GAIN_LIMIT);
        ok_a = (cfg.album_gain_db > -rgss_pkg::GAIN_LIMIT) &&
               (cfg.album_gain_db < rgss_pkg::GAIN_LIMIT);
        use_g = 1'b0;
        raw = cfg.track_gain_db;
        if (cfg.metadata_present) begin
            priority if (!cfg.prefer_album && ok_t) begin
                use_g = 1'b1;
                raw = cfg.track_gain_db;
            end else if (ok_a) begin
                use_g = 1'b1;
                raw = cfg.album_gain_db;
            end else if (cfg.prefer_album && ok_t) begin
                use_g = 1'b1;
                raw = cfg.track_gain_db;
            end
        end
        m16 = raw[15] ? 16'(-raw) : 16'(raw);
        m14 = m16[13:0];
        priority if (m14 >= 14'(2 * rgss_pkg::DB_STEP)) begin
            k_sel = 2'd2;
            r_wide = m14 - 14'(2 * rgss_pkg::DB_STEP);
        end else if (m14 >= rgss_pkg::DB_STEP) begin
            k_sel = 2'd1;
            r_wide = m14 - rgss_pkg::DB_STEP;
        end else begin
            k_sel = 2'd0;
            r_wide = m14;
        end
    end

    always_comb begin
        state_next = state_reg;
        gain_next = gain_reg;
        acc_next = acc_reg;
        a_next = a_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        bit_next = bit_reg;
        r_next = r_reg;
        k_next = k_reg;
        neg_next = neg_reg;
        prod = 64'(acc_reg) * 64'(rgss_pkg::POW_TABLE[bit_reg]);
        prod_rnd = 65'(prod) + 65'(64'd1 << 28);
        unique case (k_reg)
            2'd0:    mult = 7'd1;
            2'd1:    mult = 7'd10;
            default: mult = 7'd100;
        endcase
        rem_sh = {rem_reg, num_reg[51]};
        qb = rem_sh >= {1'b0, a_reg};
        unique case (state_reg)
            rgss_pkg::GS_IDLE: begin
            end
            rgss_pkg::GS_START: begin
                if (!use_g) begin
                    gain_next = rgss_pkg::UNITY_GAIN;
                    state_next = rgss_pkg::GS_IDLE;
                end else begin
                    neg_next = raw[15];
                    k_next = k_sel;
                    r_next = r_wide[12:0];
                    acc_next = 32'h1000_0000;
                    bit_next = '0;
                    state_next = rgss_pkg::GS_MUL;
                end
            end
            rgss_pkg::GS_MUL: begin
                // one table factor per cycle for each set bit of the remainder
                if (r_reg[bit_reg]) begin
                    acc_next = prod_rnd[60:29];
                end
                if (bit_reg == 4'(rgss_pkg::POW_DEPTH - 1)) begin
                    state_next = rgss_pkg::GS_SCALE;
                end else begin
                    bit_next = bit_reg + 4'd1;
                end
            end
            rgss_pkg::GS_SCALE: begin
                a_next = 39'(acc_reg) * 39'(mult);
                state_next = neg_reg ? rgss_pkg::GS_DIVINIT : rgss_pkg::GS_POS;
            end
            rgss_pkg::GS_POS: begin
                gain_next = 32'((40'(a_reg) + 40'd16) >> 5);
                state_next = rgss_pkg::GS_IDLE;
            end
            rgss_pkg::GS_DIVINIT: begin
                num_next = (52'd1 << 51) + 52'(a_reg >> 1);
                rem_next = '0;
                q_next = '0;
                cnt_next = '0;
                state_next = rgss_pkg::GS_DIV;
            end
            rgss_pkg::GS_DIV: begin
                // restoring division, one quotient bit per cycle
                rem_next = qb ? 39'(rem_sh - {1'b0, a_reg}) : rem_sh[38:0];
                num_next = {num_reg[50:0], 1'b0};
                q_next = {q_reg[30:0], qb};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd51) begin
                    gain_next = {q_reg[30:0], qb};
                    state_next = rgss_pkg::GS_IDLE;
                end
            end
            default: state_next = rgss_pkg::GS_IDLE;
        endcase
        if (start) begin
            state_next = rgss_pkg::GS_START;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rgss_pkg::GS_IDLE;
            gain_reg <= rgss_pkg::UNITY_GAIN;
        end else begin
            state_reg <= state_next;
            gain_reg <= gain_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg <= a_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        cnt_reg <= cnt_next;
        bit_reg <= bit_next;
        r_reg <= r_next;
        k_reg <= k_next;
        neg_reg <= neg_next;
    end

    assign busy = state_reg != rgss_pkg::GS_IDLE;
    assign linear_gain = gain_reg;

endmodule

/* rtl/rgss_pipe.sv */
// five stage sample datapath: decode, multiply, normalize/clamp, shift, round and pack
module rgss_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_sample,
    input  logic                in_last,
    input  rgss_pkg::fmt_t      fmt,
    input  logic [31:0]         linear_gain,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_sample,
    output logic                out_last
);

    rgss_pkg::stage_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    rgss_pkg::stage_t s1_next, s2_next, s3_next, s4_next, s5_next;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // a stage moves when it is empty or its successor moves
    assign rdy5 = !v5_reg || out_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // decode
    always_comb begin
        s1_next = '0;
        s1_next.fmt = fmt;
        s1_next.raw = in_sample;
        s1_next.last = in_last;
        s1_next.e = 8'd1;
        unique case (fmt)
            rgss_pkg::FMT_S16: begin
                s1_next.neg = in_sample[15];
                s1_next.mag = in_sample[15] ? 32'(17'h10000 - 17'(in_sample[15:0]))
                                            : 32'(in_sample[15:0]);
            end
            rgss_pkg::FMT_S32: begin
                s1_next.neg = in_sample[31];
                s1_next.mag = in_sample[31] ? -in_sample : in_sample;
            end
            rgss_pkg::FMT_F32: begin
                s1_next.neg = in_sample[31];
                s1_next.spec = (in_sample[30:23] == 8'hFF) || (in_sample[30:0] == '0);
                s1_next.mag = {8'd0, in_sample[30:23] != 8'd0, in_sample[22:0]};
                s1_next.e = (in_sample[30:23] == 8'd0) ? 8'd1 : in_sample[30:23];
            end
            default: begin
                s1_next.spec = 1'b1;
            end
        endcase
    end

    // multiply
    always_comb begin
        s2_next = s1_reg;
        s2_next.p = 64'(s1_reg.mag) * 64'(linear_gain);
    end

    // integer clamp, float leading one
    logic [40:0] q;
    logic [32:0] qc;
    always_comb begin
        s3_next = s2_reg;
        q = s2_reg.p[63:23];
        qc = '0;
        s3_next.h = '0;
        for (int i = 0; i < 56; i++) begin
            if (s2_reg.p[i]) begin
                s3_next.h = 6'(i);
            end
        end
        unique case (s2_reg.fmt)
            rgss_pkg::FMT_S16: begin
                if (s2_reg.neg) begin
                    qc = (q > 41'd32768) ? 33'd32768 : 33'(q);
                    s3_next.res = {16'd0, 16'(-qc)};
                end else begin
                    qc = (q > 41'd32767) ? 33'd32767 : 33'(q);
                    s3_next.res = {16'd0, qc[15:0]};
                end
            end
            rgss_pkg::FMT_S32: begin
                if (s2_reg.neg) begin
                    qc = (q > 41'h8000_0000) ? 33'h8000_0000 : 33'(q);
                    s3_next.res = 32'(-qc);
                end else begin
                    qc = (q > 41'h7FFF_FFFF) ? 33'h7FFF_FFFF : 33'(q);
                    s3_next.res = qc[31:0];
                end
            end
            default: begin
                s3_next.res = s2_reg.raw;
            end
        endcase
    end

    // float exponent and alignment shift with round and sticky bits
    logic signed [10:0] ex0;
    logic signed [10:0] sh;
    logic [5:0]         amt;
    logic [63:0]        pshift;
    always_comb begin
        s4_next = s3_reg;
        ex0 = $signed({3'd0, s3_reg.e}) + $signed({5'd0, s3_reg.h}) - 11'sd46;
        if (ex0 < 11'sd1) begin
            sh = 11'sd24 - $signed({3'd0, s3_reg.e});
            s4_next.ex = 11'sd1;
        end else begin
            sh = $signed({5'd0, s3_reg.h}) - 11'sd23;
            s4_next.ex = ex0;
        end
        s4_next.rb = 1'b0;
        s4_next.st = 1'b0;
        if (sh <= 11'sd0) begin
            amt = 6'(-sh);
            pshift = s3_reg.p << amt;
            s4_next.mant = pshift[24:0];
        end else begin
            amt = 6'(sh);
            pshift = s3_reg.p >> amt;
            s4_next.mant = pshift[24:0];
            s4_next.rb = s3_reg.p[amt - 6'd1];
            s4_next.st = (s3_reg.p & ((64'd1 << (amt - 6'd1)) - 64'd1)) != '0;
        end
    end

    // round to nearest even and pack
    logic               inc;
    logic [24:0]        m2;
    logic signed [10:0] ex2;
    always_comb begin
        s5_next = s4_reg;
        inc = s4_reg.rb && (s4_reg.st || s4_reg.mant[0]);
        m2 = s4_reg.mant + 25'(inc);
        ex2 = s4_reg.ex;
        if (m2[24]) begin
            m2 = m2 >> 1;
            ex2 = ex2 + 11'sd1;
        end
        if (s4_reg.fmt == rgss_pkg::FMT_F32 && !s4_reg.spec) begin
            priority if (ex2 >= 11'sd255) begin
                s5_next.res = {s4_reg.neg, 31'h7F80_0000};
            end else if (m2 < 25'h80_0000) begin
                s5_next.res = {s4_reg.neg, 8'd0, m2[22:0]};
            end else begin
                s5_next.res = {s4_reg.neg, ex2[7:0], m2[22:0]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) s1_reg <= s1_next;
        if (rdy2 && v1_reg) s2_reg <= s2_next;
        if (rdy3 && v2_reg) s3_reg <= s3_next;
        if (rdy4 && v3_reg) s4_reg <= s4_next;
        if (rdy5 && v4_reg) s5_reg <= s5_next;
    end

    assign out_valid = v5_reg;
    assign out_sample = s5_reg.res;
    assign out_last = s5_reg.last;

endmodule

/* rtl/replay_gain_sample_scaler.sv */
// Replay gain sample scaler top level. Samples stream through a five stage pipeline at
// one transfer per cycle unless m_tready stalls it or a gain update runs; the output stage
// holds a finished result while earlier stages keep filling. Each write to a known
// configuration register starts the gain sequencer, which walks the 13 entry power table
// one entry per cycle and, for negative gains, a 52 step restoring divider; s_tready stays
// low while it runs.
module replay_gain_sample_scaler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // sample_out
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_addr,
    input  logic [15:0] cfg_wr_data
);

    rgss_pkg::gain_cfg_t cfg_reg;
    rgss_pkg::fmt_t      fmt_reg;
    logic                busy;
    logic                start;
    logic                pipe_ready;
    logic [31:0]         linear_gain;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
            fmt_reg <= rgss_pkg::FMT_S16;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                rgss_pkg::REG_TRACK:   cfg_reg.track_gain_db <= cfg_wr_data;
                rgss_pkg::REG_ALBUM:   cfg_reg.album_gain_db <= cfg_wr_data;
                rgss_pkg::REG_PREFER:  cfg_reg.prefer_album <= cfg_wr_data[0];
                rgss_pkg::REG_PRESENT: cfg_reg.metadata_present <= cfg_wr_data[0];
                rgss_pkg::REG_FORMAT:  fmt_reg <= rgss_pkg::fmt_t'(cfg_wr_data[1:0]);
                default: begin
                end
            endcase
        end
    end

    assign start = cfg_wr_en && (cfg_wr_addr <= rgss_pkg::REG_FORMAT);

    rgss_gain u_gain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .cfg         (cfg_reg),
        .busy        (busy),
        .linear_gain (linear_gain)
    );

    rgss_pipe u_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid && !busy),
        .in_ready    (pipe_ready),
        .in_sample   (s_tdata),
        .in_last     (s_tlast),
        .fmt         (fmt_reg),
        .linear_gain (linear_gain),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_sample  (m_tdata),
        .out_last    (m_tlast)
    );

    assign s_tready = pipe_ready && !busy;

endmodule

/* rtl/rgss_checker.sv */
// port level checks for the replay gain sample scaler
`include "replay_gain_sample_scaler_defines.svh"

module rgss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_wr_en,
    input logic [2:0]  cfg_wr_addr
);

    // a stalled result holds
    `RGSS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // nothing comes out right after reset
    `RGSS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result after reset")

    // a register write starts the gain update, which blocks new samples
    `RGSS_ASSERT(a_cfg_block, cfg_wr_en && (cfg_wr_addr <= rgss_pkg::REG_FORMAT) |=> !s_tready, "sample taken during gain update")

endmodule

bind replay_gain_sample_scaler rgss_checker u_rgss_checker (.*);
